[rtl/core/hta_pkg.sv]
// Shared constants, codes and types of the handle table allocator.
`timescale 1ns / 1ps

package hta_pkg;

  // Table size and the widths that follow from it.
  localparam int NUM_SLOTS    = 64;
  localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Fixed field widths of the request and result items.
  localparam int REQ_W        = 2;
  localparam int WORD_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int NEW_HANDLE_W = 7;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // Operation classes handed from the front end to the back end.
  typedef logic [2:0] op_kind_t;
  localparam op_kind_t OP_ALLOC   = 3'd0;
  localparam op_kind_t OP_REJECT  = 3'd1;
  localparam op_kind_t OP_FREE    = 3'd2;
  localparam op_kind_t OP_LOOKUP  = 3'd3;
  localparam op_kind_t OP_INVALID = 3'd4;

  // One classified request.
  typedef struct packed {
    op_kind_t           kind;
    logic [SLOT_W-1:0]  slot;
    logic [WORD_W-1:0]  object_id;
    logic [WORD_W-1:0]  access_rights;
    logic [WORD_W-1:0]  entry_flags;
  } hta_op_t;

  // Queue head offered to the back end.
  typedef struct packed {
    logic    valid;
    hta_op_t op;
  } hta_link_t;

endpackage

[rtl/core/hta_front.sv]
// Front end: takes request items, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module hta_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [hta_pkg::REQ_W-1:0]           in_req_type,
  input  logic [hta_pkg::WORD_W-1:0]          in_object_id,
  input  logic [hta_pkg::WORD_W-1:0]          in_access_rights,
  input  logic [hta_pkg::WORD_W-1:0]          in_entry_flags,
  input  logic [hta_pkg::WORD_W-1:0]          in_handle,
  output hta_pkg::hta_link_t                  head,
  input  logic                                head_take
);

  localparam int QDEPTH = 2;

  hta_pkg::hta_op_t op_cls;
  logic             handle_ok;
  logic             push;
  logic             pop;

  hta_pkg::hta_op_t q_mem_r [QDEPTH];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  // A handle names slot handle-1; null and out-of-range handles are invalid.
  assign handle_ok = (in_handle != '0) &&
                     (in_handle <= hta_pkg::WORD_W'(hta_pkg::NUM_SLOTS));

  // Classify the item so the back end only has to carry it out.
  always_comb begin
    op_cls.slot          = hta_pkg::SLOT_W'(in_handle - hta_pkg::WORD_W'(1));
    op_cls.object_id     = in_object_id;
    op_cls.access_rights = in_access_rights;
    op_cls.entry_flags   = in_entry_flags;
    unique case (in_req_type)
      hta_pkg::REQ_ALLOC: begin
        op_cls.kind = (in_object_id != '0) ? hta_pkg::OP_ALLOC : hta_pkg::OP_REJECT;
      end
      hta_pkg::REQ_FREE: begin
        op_cls.kind = handle_ok ? hta_pkg::OP_FREE : hta_pkg::OP_INVALID;
      end
      hta_pkg::REQ_LOOKUP: begin
        op_cls.kind = handle_ok ? hta_pkg::OP_LOOKUP : hta_pkg::OP_INVALID;
      end
      default: begin
        op_cls.kind = hta_pkg::OP_INVALID;
      end
    endcase
  end

  // Two-entry queue between the front and back ends.
  assign in_full    = (count_r == 2'(QDEPTH));
  assign push       = in_push && !in_full;
  assign pop        = head.valid && head_take;
  assign wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_cls;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.op    = q_mem_r[rd_ptr_r];

endmodule

[rtl/core/hta_back.sv]
// Back end: slot store, free-slot search and result register.
`timescale 1ns / 1ps

module hta_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hta_pkg::hta_link_t                  head,
  output logic                                head_take,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [hta_pkg::STATUS_W-1:0]        out_status,
  output logic [hta_pkg::NEW_HANDLE_W-1:0]    out_new_handle,
  output logic [hta_pkg::WORD_W-1:0]          out_found_object,
  output logic                                out_acquire_ref,
  output logic                                out_release_ref
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                                state_r;
  logic                                state_nxt;

  // Slot stores: object ids and the rights/flags pair of each handle.
  logic [hta_pkg::WORD_W-1:0]          obj_mem   [hta_pkg::NUM_SLOTS];
  logic [2*hta_pkg::WORD_W-1:0]        attr_mem  [hta_pkg::NUM_SLOTS];
  logic [hta_pkg::NUM_SLOTS-1:0]       valid_r;
  logic [hta_pkg::NUM_SLOTS-1:0]       valid_nxt;
  logic [hta_pkg::WORD_W-1:0]          rd_data_r;

  hta_pkg::hta_op_t                    op_r;
  logic [hta_pkg::SLOT_W-1:0]          free_idx;
  logic                                free_any;
  logic [hta_pkg::SLOT_W-1:0]          free_idx_r;
  logic                                full_r;

  logic                                retire;
  logic                                slot_valid;
  logic                                obj_we;
  logic                                attr_we;
  logic [hta_pkg::SLOT_W-1:0]          attr_addr;
  logic [2*hta_pkg::WORD_W-1:0]        attr_wdata;

  logic                                res_valid_r;
  logic                                res_valid_nxt;
  logic [hta_pkg::STATUS_W-1:0]        status_r;
  logic [hta_pkg::STATUS_W-1:0]        status_nxt;
  logic [hta_pkg::NEW_HANDLE_W-1:0]    new_handle_r;
  logic [hta_pkg::NEW_HANDLE_W-1:0]    new_handle_nxt;
  logic [hta_pkg::WORD_W-1:0]          found_r;
  logic [hta_pkg::WORD_W-1:0]          found_nxt;
  logic                                acquire_r;
  logic                                acquire_nxt;
  logic                                release_r;
  logic                                release_nxt;

  // Lowest free slot, searched over the valid bits.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = hta_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = hta_pkg::SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

  // Take an item in the idle state; retire it once the result register is free.
  assign head_take = (state_r == S_IDLE) && head.valid;
  assign retire    = (state_r == S_EXEC) && (!res_valid_r || out_pop);
  assign state_nxt = head_take ? S_EXEC : (retire ? S_IDLE : state_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the operation, the slot read and the free-slot search result.
  always_ff @(posedge clk) begin
    if (head_take) begin
      op_r       <= head.op;
      free_idx_r <= free_idx;
      full_r     <= !free_any;
      rd_data_r  <= obj_mem[head.op.slot];
    end
  end

  // An empty slot reads as object zero through its valid bit.
  assign slot_valid = valid_r[op_r.slot];

  // Carry out the operation and form the result.
  always_comb begin
    status_nxt     = hta_pkg::ST_INVALID;
    new_handle_nxt = '0;
    found_nxt      = '0;
    acquire_nxt    = 1'b0;
    release_nxt    = 1'b0;
    obj_we         = 1'b0;
    attr_we        = 1'b0;
    attr_addr      = op_r.slot;
    attr_wdata     = '0;
    valid_nxt      = valid_r;
    unique case (op_r.kind)
      hta_pkg::OP_ALLOC: begin
        if (full_r) begin
          status_nxt = hta_pkg::ST_FULL;
        end else begin
          status_nxt     = hta_pkg::ST_OK;
          new_handle_nxt = hta_pkg::NEW_HANDLE_W'({1'b0, free_idx_r} +
                                                  (hta_pkg::SLOT_W + 1)'(1));
          acquire_nxt    = 1'b1;
          obj_we         = retire;
          attr_we        = retire;
          attr_addr      = free_idx_r;
          attr_wdata     = {op_r.access_rights, op_r.entry_flags};
          valid_nxt[free_idx_r] = 1'b1;
        end
      end
      hta_pkg::OP_REJECT: begin
        status_nxt = hta_pkg::ST_FULL;
      end
      hta_pkg::OP_FREE: begin
        if (slot_valid) begin
          status_nxt  = hta_pkg::ST_OK;
          found_nxt   = rd_data_r;
          release_nxt = 1'b1;
          attr_we     = retire;
          valid_nxt[op_r.slot] = 1'b0;
        end
      end
      hta_pkg::OP_LOOKUP: begin
        status_nxt = hta_pkg::ST_OK;
        found_nxt  = slot_valid ? rd_data_r : '0;
      end
      default: begin
        status_nxt = hta_pkg::ST_INVALID;
      end
    endcase
  end

  // Valid bits mark occupied slots; reset frees every slot at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (retire) begin
      valid_r <= valid_nxt;
    end
  end

  // Store writes. The rights and flags words are kept with each handle.
  always_ff @(posedge clk) begin
    if (obj_we) begin
      obj_mem[free_idx_r] <= op_r.object_id;
    end
    if (attr_we) begin
      attr_mem[attr_addr] <= attr_wdata;
    end
  end

  // Result register towards the output queue interface.
  assign res_valid_nxt = retire ? 1'b1 : (out_pop ? 1'b0 : res_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      status_r     <= status_nxt;
      new_handle_r <= new_handle_nxt;
      found_r      <= found_nxt;
      acquire_r    <= acquire_nxt;
      release_r    <= release_nxt;
    end
  end

  assign out_empty        = !res_valid_r;
  assign out_status       = status_r;
  assign out_new_handle   = new_handle_r;
  assign out_found_object = found_r;
  assign out_acquire_ref  = acquire_r;
  assign out_release_ref  = release_r;

endmodule

[rtl/core/handle_table_allocator.sv]
// Top level of the handle table allocator: front end, request queue and back end.
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// in_       in_push / in_full     req_type, object_id, access_rights, entry_flags, handle
// out_      out_pop / out_empty   status, new_handle, found_object, acquire_ref, release_ref
//
// In the back end the idle state takes an item, reads the object store and
// searches the valid bits for the lowest free slot; the execute state updates
// the slot and loads the result register once it is free; only then is a new item taken.
// Reset is synchronous and frees every slot at once through the valid bits.
// A two-entry queue keeps taking items while a result waits to be popped.

module handle_table_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [hta_pkg::REQ_W-1:0]           in_req_type,
  input  logic [hta_pkg::WORD_W-1:0]          in_object_id,
  input  logic [hta_pkg::WORD_W-1:0]          in_access_rights,
  input  logic [hta_pkg::WORD_W-1:0]          in_entry_flags,
  input  logic [hta_pkg::WORD_W-1:0]          in_handle,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [hta_pkg::STATUS_W-1:0]        out_status,
  output logic [hta_pkg::NEW_HANDLE_W-1:0]    out_new_handle,
  output logic [hta_pkg::WORD_W-1:0]          out_found_object,
  output logic                                out_acquire_ref,
  output logic                                out_release_ref
);

  hta_pkg::hta_link_t head;
  logic               head_take;

  // Classification and queueing of request items.
  hta_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_object_id     (in_object_id),
    .in_access_rights (in_access_rights),
    .in_entry_flags   (in_entry_flags),
    .in_handle        (in_handle),
    .head             (head),
    .head_take        (head_take)
  );

  // Slot store and result generation.
  hta_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .head_take        (head_take),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_new_handle   (out_new_handle),
    .out_found_object (out_found_object),
    .out_acquire_ref  (out_acquire_ref),
    .out_release_ref  (out_release_ref)
  );

`ifndef ASSERT_OFF
  // An item never both takes and drops a reference.
  a_ref_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_acquire_ref && out_release_ref))
    else $error("acquire and release flagged on the same item");

  // A reference is only taken with an ok status.
  a_acquire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_acquire_ref) |-> (out_status == hta_pkg::ST_OK))
    else $error("acquire flagged without ok status");

  // A released object was stored, so it is never the null object.
  a_release_object: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_release_ref) |-> (out_found_object != '0))
    else $error("release of a null object");

  // A rejected request or an allocation into a full table reports neither a handle nor a reference.
  a_full_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == hta_pkg::ST_FULL) |->
      (out_new_handle == '0 && !out_acquire_ref && !out_release_ref))
    else $error("full status with a handle or reference");
`endif

endmodule
